// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, limits and types shared by the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  localparam int QUAT_W      = 16;  // Q1.14 components
  localparam int VEC_W       = 16;  // integer-scale vector components
  localparam int QEXT_W      = 17;  // quaternion after optional negation
  localparam int PV_W        = 33;  // quaternion x vector product
  localparam int T_W         = 34;  // t = 2*cross(q,v), units 2^-14
  localparam int P_W         = 50;  // second-level products, units 2^-28
  localparam int S_W         = 51;  // biased sum, units 2^-28
  localparam int SUM_SHIFT   = 28;
  localparam int RND_W       = S_W - SUM_SHIFT;  // rounded integer width
  localparam int ROT_W       = 18;
  localparam int IN_TDATA_W  = 7 * 16;
  localparam int OUT_TDATA_W = ((3 * ROT_W + 7) / 8) * 8;
  localparam int STAGES      = 6;

  localparam logic signed [RND_W-1:0] ROT_MAX = RND_W'(131071);
  localparam logic signed [RND_W-1:0] ROT_MIN = -RND_W'(131072);

  typedef logic signed [QEXT_W-1:0] qext_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [PV_W-1:0]   pv_t;
  typedef logic signed [T_W-1:0]    tvec_t;
  typedef logic signed [P_W-1:0]    prod_t;
  typedef logic signed [S_W-1:0]    sum_t;
  typedef logic signed [ROT_W-1:0]  rot_t;

endpackage

`default_nettype wire

// ===== rtl/quaternion_vector_rotate_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates a 3-vector by a fixed-point quaternion (or its inverse), with
// round-to-nearest and 18-bit saturation of the result.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_* : tdata holds quat x,y,z,w then vec x,y,z,
//   16 bits each; tuser is the inverse flag. Results leave on out_* : tdata
//   holds rot x,y,z at 18 bits each, tuser is the saturation flag.
//   One word is taken every cycle while the output is not stalled. Words
//   pass through a six-stage multiply/add pipeline (input/negate, q*v
//   products, cross difference, w*t and q*t products, partial sums, final
//   sum with round and clamp).
//   When the receiver holds out_tready low with a result waiting, the whole
//   pipeline freezes and in_tready drops in the same cycle; nothing is lost
//   or repeated. Empty stages do not block: in_tready stays high while the
//   output stage is empty.
//   Reset (rst_n low, synchronous) clears all stage valid bits; data
//   registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z (16 bits each)
  input  wire  [qvr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // rot_x, rot_y, rot_z (18 bits each), zero pad
  output logic [qvr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // clipped
  output logic                              out_tuser
);
  import qvr_pkg::*;

  logic [STAGES-1:0] vld_r;
  logic              en;

  assign en         = !vld_r[STAGES-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], in_tvalid};
    end
  end

  // stage 1: unpack, optional conjugate
  qext_t q1_r [3];
  quat_t w1_r;
  vec_t  v1_r [3];
  // stage 2: q*v products
  qext_t q2_r [3];
  quat_t w2_r;
  vec_t  v2_r [3];
  pv_t   pa2_r [3];
  pv_t   pb2_r [3];
  // stage 3: t
  qext_t q3_r [3];
  quat_t w3_r;
  vec_t  v3_r [3];
  tvec_t t3_r [3];
  // stage 4: w*t and q*t products
  vec_t  v4_r [3];
  prod_t wt4_r [3];
  prod_t ca4_r [3];
  prod_t cb4_r [3];
  // stage 5: partial sums
  sum_t  vw5_r [3];
  sum_t  cd5_r [3];
  // stage 6: output
  rot_t  rot6_r [3];
  logic  [2:0] clip6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r <= quat_t'(in_tdata[3*QUAT_W +: QUAT_W]);
      w2_r <= w1_r;
      w3_r <= w2_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    qext_t q_in;
    qext_t q_nxt;
    logic signed [T_W-1:0] d3_nxt;
    sum_t  ve5;
    sum_t  s6;
    logic signed [RND_W-1:0] r6;
    rot_t  rot_nxt;
    logic  clip_nxt;

    assign q_in  = QEXT_W'(quat_t'(in_tdata[i*QUAT_W +: QUAT_W]));
    assign q_nxt = in_tuser ? -q_in : q_in;

    assign d3_nxt = T_W'(pa2_r[i]) - T_W'(pb2_r[i]);
    assign ve5    = S_W'(v4_r[i]);
    assign s6     = vw5_r[i] + cd5_r[i];
    assign r6     = s6[S_W-1:SUM_SHIFT];   // floor of biased sum

    always_comb begin
      rot_nxt  = r6[ROT_W-1:0];
      clip_nxt = 1'b0;
      if (r6 > ROT_MAX) begin
        rot_nxt  = ROT_MAX[ROT_W-1:0];
        clip_nxt = 1'b1;
      end else if (r6 < ROT_MIN) begin
        rot_nxt  = ROT_MIN[ROT_W-1:0];
        clip_nxt = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q1_r[i]   <= q_nxt;
        v1_r[i]   <= vec_t'(in_tdata[(4+i)*VEC_W +: VEC_W]);

        q2_r[i]   <= q1_r[i];
        v2_r[i]   <= v1_r[i];
        pa2_r[i]  <= PV_W'(q1_r[J]) * PV_W'(v1_r[K]);
        pb2_r[i]  <= PV_W'(q1_r[K]) * PV_W'(v1_r[J]);

        q3_r[i]   <= q2_r[i];
        v3_r[i]   <= v2_r[i];
        t3_r[i]   <= d3_nxt <<< 1;

        v4_r[i]   <= v3_r[i];
        wt4_r[i]  <= P_W'(w3_r) * P_W'(t3_r[i]);
        ca4_r[i]  <= P_W'(q3_r[J]) * P_W'(t3_r[K]);
        cb4_r[i]  <= P_W'(q3_r[K]) * P_W'(t3_r[J]);

        // round-half-up bias folded in here
        vw5_r[i]  <= (ve5 <<< SUM_SHIFT) + S_W'(wt4_r[i]) + (S_W'(1) <<< (SUM_SHIFT - 1));
        cd5_r[i]  <= S_W'(ca4_r[i]) - S_W'(cb4_r[i]);

        rot6_r[i] <= rot_nxt;
        clip6_r[i] <= clip_nxt;
      end
    end
  end

  assign out_tdata = {{(OUT_TDATA_W - 3*ROT_W){1'b0}}, rot6_r[2], rot6_r[1], rot6_r[0]};
  assign out_tuser = |clip6_r;

  // ---------------------------------------------------------------- checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input blocked without output stall");

  a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (rot6_r[0] == ROT_MAX[ROT_W-1:0]) || (rot6_r[0] == ROT_MIN[ROT_W-1:0]) ||
      (rot6_r[1] == ROT_MAX[ROT_W-1:0]) || (rot6_r[1] == ROT_MIN[ROT_W-1:0]) ||
      (rot6_r[2] == ROT_MAX[ROT_W-1:0]) || (rot6_r[2] == ROT_MIN[ROT_W-1:0]))
    else $error("clip flag set with no component at a limit");

endmodule

`default_nettype wire

// ===== tb/sv/quaternion_vector_rotate_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top_tb
// Streams quaternion/vector words into the rotator and scores every result
// word against a bit-exact fixed-point rotation computed in the bench.
// Both stream sides idle and stall at random, with calm stretches between.
// ----------------------------------------------------------------------------

module quaternion_vector_rotate_top_tb;

  import qvr_pkg::*;

  typedef enum logic {
    ROT_BY_Q   = 1'b0,
    ROT_BY_INV = 1'b1
  } rot_dir_e;

  typedef struct packed {
    quat_t    qx;
    quat_t    qy;
    quat_t    qz;
    quat_t    qw;
    vec_t     vx;
    vec_t     vy;
    vec_t     vz;
    rot_dir_e dir;
  } rot_req_t;

  typedef struct packed {
    rot_t x;
    rot_t y;
    rot_t z;
    logic clip;
  } rot_res_t;

  localparam int     RANDOM_WORDS = 1400;
  localparam longint HALF_LSB     = longint'(1) <<< (SUM_SHIFT - 1);
  localparam longint ROT_HI       = (longint'(1) <<< (ROT_W - 1)) - 1;
  localparam longint ROT_LO       = -(longint'(1) <<< (ROT_W - 1));

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  rot_req_t rot_req_q[$];
  rot_res_t expected_rot_q[$];
  rot_req_t cur_req;
  int       send_wait  = 0;
  int       recv_wait  = 0;
  int       recv_draw  = 0;
  bit       send_calm  = 1'b0;
  bit       recv_calm  = 1'b0;
  int       fail_cnt   = 0;

  quaternion_vector_rotate_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // v' = v + w*t + cross(q,t), t = 2*cross(q,v); sums kept exact in 2^-28 units
  function automatic rot_res_t rotate_vector(rot_req_t r);
    longint   qx, qy, qz, qw, vx, vy, vz, tx, ty, tz, rnd;
    longint   acc[3];
    rot_t     comp[3];
    rot_res_t res;
    qx = r.qx;
    qy = r.qy;
    qz = r.qz;
    qw = r.qw;
    vx = r.vx;
    vy = r.vy;
    vz = r.vz;
    if (r.dir == ROT_BY_INV) begin
      qx = -qx;
      qy = -qy;
      qz = -qz;
    end
    tx = 2 * (qy * vz - qz * vy);
    ty = 2 * (qz * vx - qx * vz);
    tz = 2 * (qx * vy - qy * vx);
    acc[0] = (vx <<< SUM_SHIFT) + qw * tx + (qy * tz - qz * ty);
    acc[1] = (vy <<< SUM_SHIFT) + qw * ty + (qz * tx - qx * tz);
    acc[2] = (vz <<< SUM_SHIFT) + qw * tz + (qx * ty - qy * tx);
    res.clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      // round half up, then clamp to 18 bits
      rnd = (acc[i] + HALF_LSB) >>> SUM_SHIFT;
      if (rnd > ROT_HI) begin
        rnd = ROT_HI;
        res.clip = 1'b1;
      end
      if (rnd < ROT_LO) begin
        rnd = ROT_LO;
        res.clip = 1'b1;
      end
      comp[i] = rot_t'(rnd);
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    return res;
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = ~calm;
    return calm ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic logic [15:0] pick_comp(int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 32768) - 16384);  // roughly unit scale
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h4000;
          3: return 16'hc000;
          4: return 16'h0000;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic push_req(input logic [15:0] qx, qy, qz, qw, vx, vy, vz,
                          input rot_dir_e dir);
    rot_req_t r;
    r.qx  = qx;
    r.qy  = qy;
    r.qz  = qz;
    r.qw  = qw;
    r.vx  = vx;
    r.vy  = vy;
    r.vz  = vz;
    r.dir = dir;
    rot_req_q.push_back(r);
  endtask

  task automatic report_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      fail_cnt++;
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
    end
  endtask

  task automatic check_result();
    rot_res_t exp_r;
    rot_t     got_x, got_y, got_z;
    if (expected_rot_q.size() == 0) begin
      fail_cnt++;
      $error("result word with no rotation pending");
    end else begin
      exp_r = expected_rot_q.pop_front();
      got_x = $signed(out_tdata[ROT_W-1:0]);
      got_y = $signed(out_tdata[2*ROT_W-1:ROT_W]);
      got_z = $signed(out_tdata[3*ROT_W-1:2*ROT_W]);
      report_field("rot_x", exp_r.x, got_x);
      report_field("rot_y", exp_r.y, got_y);
      report_field("rot_z", exp_r.z, got_z);
      report_field("clipped", exp_r.clip, out_tuser);
    end
  endtask

  // driver: one word per handshake, random gap after each issue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_rot_q.push_back(rotate_vector(cur_req));
      if (in_tvalid && !in_tready) begin
        // hold the word until taken
      end else if (send_wait > 0) begin
        in_tvalid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (rot_req_q.size() > 0) begin
        cur_req = rot_req_q.pop_front();
        in_tdata  <= {cur_req.vz, cur_req.vy, cur_req.vx,
                      cur_req.qw, cur_req.qz, cur_req.qy, cur_req.qx};
        in_tuser  <= cur_req.dir;
        in_tvalid <= 1'b1;
        send_wait <= draw_wait(send_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: score each result, then stall ready for a random count
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait  <= 0;
    end else if (out_tvalid && out_tready) begin
      check_result();
      recv_draw = draw_wait(recv_calm);
      recv_wait  <= recv_draw;
      out_tready <= (recv_draw == 0);
    end else if (!out_tready) begin
      if (recv_wait <= 1) out_tready <= 1'b1;
      if (recv_wait > 0) recv_wait <= recv_wait - 1;
    end
  end

  initial begin
    int style;
    // zero input, identity with vector extremes
    push_req(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ROT_BY_Q);
    push_req(16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h7fff, 16'h8000, 16'h0001, ROT_BY_Q);
    push_req(16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'h7fff, 16'hffff, ROT_BY_INV);
    // quarter turns about each axis; both directions about z
    push_req(16'h0000, 16'h0000, 16'h2d41, 16'h2d41, 16'd1000, 16'h0000, 16'h0000, ROT_BY_Q);
    push_req(16'h0000, 16'h0000, 16'h2d41, 16'h2d41, 16'd1000, 16'h0000, 16'h0000, ROT_BY_INV);
    push_req(16'h2d41, 16'h0000, 16'h0000, 16'h2d41, 16'h0000, 16'd1000, 16'h0000, ROT_BY_Q);
    push_req(16'h0000, 16'h2d41, 16'h0000, 16'h2d41, 16'h0000, 16'h0000, 16'd1000, ROT_BY_INV);
    // half turn about x
    push_req(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'd100, 16'd200, 16'd300, ROT_BY_Q);
    // exact half-LSB results: each word rounds one component up from +0.5 and one from -0.5
    push_req(16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hffff, ROT_BY_Q);
    push_req(16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0001, ROT_BY_INV);
    // most negative components, negated on inverse; saturation
    push_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, ROT_BY_Q);
    push_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, ROT_BY_INV);
    push_req(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, ROT_BY_Q);
    push_req(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, ROT_BY_INV);
    push_req(16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'd12345, ROT_BY_INV);
    // tiny non-unit quaternion, and a real-only one
    push_req(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'hffff, 16'hffff, 16'hffff, ROT_BY_Q);
    push_req(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, ROT_BY_INV);
    push_req(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h7fff, 16'h7fff, 16'h8000, ROT_BY_Q);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      style = $urandom_range(0, 9);
      style = (style < 3) ? 0 : (style < 8) ? 1 : 2;
      push_req(pick_comp(style), pick_comp(style), pick_comp(style), pick_comp(style),
               pick_comp($urandom_range(0, 5) == 0 ? 2 : 0),
               pick_comp($urandom_range(0, 5) == 0 ? 2 : 0),
               pick_comp($urandom_range(0, 5) == 0 ? 2 : 0),
               rot_dir_e'($urandom_range(0, 1)));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (rot_req_q.size() > 0 || in_tvalid || expected_rot_q.size() > 0)
      @(posedge clk);
    repeat (2 * STAGES + 4) @(posedge clk);

    if (fail_cnt == 0 && expected_rot_q.size() == 0) begin
      $display("** quaternion_vector_rotate_top: PASSED **");
    end else begin
      $display("** quaternion_vector_rotate_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** quaternion_vector_rotate_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate_top.sv
tb/sv/quaternion_vector_rotate_top_tb.sv
